>>> rtl/tmsod_pkg.sv
// ----------------------------------------------------------------------------
// tmsod_pkg: shared types and constants of the thruster mixer
// Field widths, register indexes and the lane control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsod_pkg;

  // slot counts fixed by the port list
  localparam int ThrusterSlots = 8;
  localparam int AxisSlots     = 6;

  // default active counts
  localparam int DefNumThrusters = 8;
  localparam int DefNumAxes      = 6;

  // field widths
  localparam int AxisW   = 16;
  localparam int CoefW   = 8;
  localparam int CoefRegW = CoefW * ThrusterSlots;
  localparam int ProdW   = AxisW + CoefW;
  localparam int FracW   = 15;
  localparam int TermW   = ProdW - FracW;
  localparam int MixW    = 11;
  localparam int ScaleW  = 16;
  localparam int ThrW    = 11;
  localparam int OutW    = 27;
  localparam int CfgIdxW = 3;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(1);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_AXIS_0    = 3'd0,
    REG_COEF_AXIS_1    = 3'd1,
    REG_COEF_AXIS_2    = 3'd2,
    REG_COEF_AXIS_3    = 3'd3,
    REG_COEF_AXIS_4    = 3'd4,
    REG_COEF_AXIS_5    = 3'd5,
    REG_FORCE_SCALE    = 3'd6,
    REG_CHANGE_THRESH  = 3'd7
  } cfg_reg_e;

  // per-request control into every lane
  typedef struct packed {
    logic clear;   // start a new sum
    logic acc_en;  // add one axis term
    logic chk_en;  // compare against last published value, scale
    logic commit;  // sum becomes the published value
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/tmsod_lane.sv
// ----------------------------------------------------------------------------
// tmsod_lane: one thruster's mixing lane
// Steps through the axes with one 16x8 multiplier, rounds each term half away
// from zero, accumulates, checks the change and scales the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsod_lane (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tmsod_pkg::lane_ctrl_t              ctrl_i,
  input  wire logic signed [tmsod_pkg::AxisW-1:0] axis_i,
  input  wire logic signed [tmsod_pkg::CoefW-1:0] coef_i,
  input  wire logic [tmsod_pkg::ScaleW-1:0]       scale_i,
  input  wire logic [tmsod_pkg::ThrW-1:0]         thresh_i,
  output logic                                    trig_o,
  output logic signed [tmsod_pkg::OutW-1:0]       scaled_o,
  output logic signed [tmsod_pkg::MixW-1:0]       mix_o
);

  logic signed [tmsod_pkg::ProdW-1:0]  prod;
  logic signed [tmsod_pkg::ProdW-1:0]  biased;
  logic signed [tmsod_pkg::TermW-1:0]  term;
  logic signed [tmsod_pkg::MixW-1:0]   acc_q, acc_d;
  logic signed [tmsod_pkg::MixW-1:0]   last_q;
  logic signed [tmsod_pkg::MixW:0]     diff;
  logic [tmsod_pkg::MixW:0]            diff_abs;
  logic signed [tmsod_pkg::MixW+tmsod_pkg::ScaleW:0] scaled;
  logic                                trig_q;
  logic signed [tmsod_pkg::OutW-1:0]   scaled_q;

  // term = round(axis * coef / 2^15), half away from zero
  assign prod   = axis_i * coef_i;
  assign biased = prod + tmsod_pkg::ProdW'(1 << (tmsod_pkg::FracW - 1))
                - $signed({{(tmsod_pkg::ProdW-1){1'b0}}, prod[tmsod_pkg::ProdW-1]});
  assign term   = biased[tmsod_pkg::ProdW-1:tmsod_pkg::FracW];

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + tmsod_pkg::MixW'(term);
    end
  end

  // change check and output scaling
  assign diff     = (tmsod_pkg::MixW+1)'(acc_q) - (tmsod_pkg::MixW+1)'(last_q);
  assign diff_abs = diff[tmsod_pkg::MixW] ? unsigned'(-diff) : unsigned'(diff);
  assign scaled   = acc_q * $signed({1'b0, scale_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      last_q <= '0;
      trig_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (ctrl_i.chk_en) begin
        trig_q <= diff_abs > {1'b0, thresh_i};
      end
      if (ctrl_i.commit) begin
        last_q <= acc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.chk_en) begin
      scaled_q <= scaled[tmsod_pkg::OutW-1:0];
    end
  end

  assign trig_o   = trig_q;
  assign scaled_o = scaled_q;
  assign mix_o    = acc_q;

endmodule

`default_nettype wire

>>> rtl/thruster_mixer_send_on_delta_core.sv
// ----------------------------------------------------------------------------
// thruster_mixer_send_on_delta_core: joystick-to-thruster mixer
// Mixes six Q1.15 axes into eight thruster commands and publishes a result
// only when some thruster moved by more than the change threshold.
// ----------------------------------------------------------------------------
// One lane per thruster runs in parallel; each lane owns a single 16x8
// multiplier and walks the axes one per cycle, so an item occupies the block
// through accept, one mixing step per axis, check and decide, and the next
// item is taken only after that. The merge stage ORs the lane triggers;
// on a publish it loads all scaled values into the output register and the
// lanes store their sums as the new published values. A waiting result does
// not block the next item, only the decide step of an item that publishes.
// Configuration writes are always accepted; write them only while idle.
`default_nettype none

module thruster_mixer_send_on_delta_core #(
  parameter int NUM_THRUSTERS = tmsod_pkg::DefNumThrusters,
  parameter int NUM_AXES      = tmsod_pkg::DefNumAxes
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [tmsod_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [tmsod_pkg::CoefRegW-1:0]       cfg_data_i,
  // input samples
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [tmsod_pkg::AxisW-1:0]   axis_0_i,
  input  wire logic signed [tmsod_pkg::AxisW-1:0]   axis_1_i,
  input  wire logic signed [tmsod_pkg::AxisW-1:0]   axis_2_i,
  input  wire logic signed [tmsod_pkg::AxisW-1:0]   axis_3_i,
  input  wire logic signed [tmsod_pkg::AxisW-1:0]   axis_4_i,
  input  wire logic signed [tmsod_pkg::AxisW-1:0]   axis_5_i,
  // published commands
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_0_o,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_1_o,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_2_o,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_3_o,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_4_o,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_5_o,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_6_o,
  output logic signed [tmsod_pkg::OutW-1:0]         thruster_7_o
);

  localparam int AxisCntW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MIX    = 4'b0010,
    S_CHECK  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  state_e                                state_q, state_d;
  logic [AxisCntW-1:0]                   axis_cnt_q, axis_cnt_d;
  tmsod_pkg::lane_ctrl_t                 lane_ctrl;
  logic                                  in_fire, any_trig, out_load;
  logic                                  out_valid_q;

  logic [tmsod_pkg::CoefRegW-1:0]        coef_q [tmsod_pkg::AxisSlots];
  logic [tmsod_pkg::ScaleW-1:0]          scale_q;
  logic [tmsod_pkg::ThrW-1:0]            thresh_q;

  logic signed [tmsod_pkg::AxisW-1:0]    axis_in [tmsod_pkg::AxisSlots];
  logic signed [tmsod_pkg::AxisW-1:0]    axis_q  [tmsod_pkg::AxisSlots];
  logic signed [tmsod_pkg::AxisW-1:0]    axis_sel;
  logic [tmsod_pkg::CoefRegW-1:0]        coef_sel;

  logic [tmsod_pkg::ThrusterSlots-1:0]   lane_trig;
  logic signed [tmsod_pkg::OutW-1:0]     lane_scaled [tmsod_pkg::ThrusterSlots];
  logic signed [tmsod_pkg::MixW-1:0]     lane_mix    [tmsod_pkg::ThrusterSlots];
  logic signed [tmsod_pkg::OutW-1:0]     out_q       [tmsod_pkg::ThrusterSlots];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tmsod_pkg::AxisSlots; k++) begin
        coef_q[k] <= '0;
      end
      scale_q  <= tmsod_pkg::ScaleReset;
      thresh_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (tmsod_pkg::cfg_reg_e'(cfg_index_i))
        tmsod_pkg::REG_COEF_AXIS_0: coef_q[0] <= cfg_data_i;
        tmsod_pkg::REG_COEF_AXIS_1: coef_q[1] <= cfg_data_i;
        tmsod_pkg::REG_COEF_AXIS_2: coef_q[2] <= cfg_data_i;
        tmsod_pkg::REG_COEF_AXIS_3: coef_q[3] <= cfg_data_i;
        tmsod_pkg::REG_COEF_AXIS_4: coef_q[4] <= cfg_data_i;
        tmsod_pkg::REG_COEF_AXIS_5: coef_q[5] <= cfg_data_i;
        tmsod_pkg::REG_FORCE_SCALE: scale_q <= cfg_data_i[tmsod_pkg::ScaleW-1:0];
        tmsod_pkg::REG_CHANGE_THRESH: thresh_q <= cfg_data_i[tmsod_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // sample capture
  assign axis_in[0] = axis_0_i;
  assign axis_in[1] = axis_1_i;
  assign axis_in[2] = axis_2_i;
  assign axis_in[3] = axis_3_i;
  assign axis_in[4] = axis_4_i;
  assign axis_in[5] = axis_5_i;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < tmsod_pkg::AxisSlots; k++) begin
        axis_q[k] <= axis_in[k];
      end
    end
  end

  // axis select for the current mixing step
  always_comb begin
    axis_sel = '0;
    coef_sel = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (axis_cnt_q == AxisCntW'(k)) begin
        axis_sel = axis_q[k];
        coef_sel = coef_q[k];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    axis_cnt_d = axis_cnt_q;
    lane_ctrl  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          lane_ctrl.clear = 1'b1;
          axis_cnt_d      = '0;
          state_d         = S_MIX;
        end
      end
      S_MIX: begin
        lane_ctrl.acc_en = 1'b1;
        if (axis_cnt_q == AxisCntW'(NUM_AXES - 1)) begin
          state_d = S_CHECK;
        end else begin
          axis_cnt_d = axis_cnt_q + 1'b1;
        end
      end
      S_CHECK: begin
        lane_ctrl.chk_en = 1'b1;
        state_d          = S_DECIDE;
      end
      S_DECIDE: begin
        if (!any_trig) begin
          state_d = S_IDLE;
        end else if (out_load) begin
          lane_ctrl.commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      axis_cnt_q <= axis_cnt_d;
    end
  end

  // thruster lanes
  for (genvar t = 0; t < tmsod_pkg::ThrusterSlots; t++) begin : g_lane
    if (t < NUM_THRUSTERS) begin : g_on
      tmsod_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (lane_ctrl),
        .axis_i   (axis_sel),
        .coef_i   ($signed(coef_sel[t*tmsod_pkg::CoefW +: tmsod_pkg::CoefW])),
        .scale_i  (scale_q),
        .thresh_i (thresh_q),
        .trig_o   (lane_trig[t]),
        .scaled_o (lane_scaled[t]),
        .mix_o    (lane_mix[t])
      );
    end else begin : g_off
      assign lane_trig[t]   = 1'b0;
      assign lane_scaled[t] = '0;
      assign lane_mix[t]    = '0;
    end
  end

  // merge: any lane over threshold publishes all lanes
  assign any_trig = |lane_trig;
  assign out_load = (state_q == S_DECIDE) && any_trig && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int t = 0; t < tmsod_pkg::ThrusterSlots; t++) begin
        out_q[t] <= lane_scaled[t];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign thruster_0_o = out_q[0];
  assign thruster_1_o = out_q[1];
  assign thruster_2_o = out_q[2];
  assign thruster_3_o = out_q[3];
  assign thruster_4_o = out_q[4];
  assign thruster_5_o = out_q[5];
  assign thruster_6_o = out_q[6];
  assign thruster_7_o = out_q[7];

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_cnt_q <= AxisCntW'(NUM_AXES - 1))
    else $error("axis counter out of range");

  a_pub_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DECIDE && $past(any_trig))
    else $error("result published outside a triggered decide step");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !out_load) |=> !out_valid_q)
    else $error("taken result still shown");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && any_trig && !out_load) |=> state_q == S_DECIDE)
    else $error("triggered item left decide without publishing");

  // lane 0's sum stays in the mixed range
  a_mix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE |-> lane_mix[0] <= 11'sd768 && lane_mix[0] >= -11'sd768)
    else $error("mixed value out of range");

endmodule

`default_nettype wire

>>> tb/tb_thruster_mixer_send_on_delta_core.sv
// ----------------------------------------------------------------------------
// tb_thruster_mixer_send_on_delta_core: self-checking bench of the mixer core
// Programs coefficient, scale and threshold registers while the core is idle,
// drives joystick samples with random sender gaps and receiver stalls, and
// compares every published command against a bit-accurate mixing predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_thruster_mixer_send_on_delta_core;
  import tmsod_pkg::*;

  localparam int  CycleLimit  = 500000;
  localparam int  SettleCyc   = 16;     // covers one full mixing pass
  localparam int  RandPerPhase = 150;

  typedef logic [AxisSlots-1:0][AxisW-1:0]   axis_vec_t;
  typedef logic [ThrusterSlots-1:0][OutW-1:0] cmd_vec_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mixing predictor plus queue of expected thruster commands
  // --------------------------------------------------------------------------
  class mix_scoreboard;
    logic [CoefRegW-1:0] coef [AxisSlots];
    logic [ScaleW-1:0]   scale;
    logic [ThrW-1:0]     thresh;
    int                  last_pub [ThrusterSlots];
    cmd_vec_t            expected_cmds [$];
    int                  errors;

    function new();
      for (int k = 0; k < AxisSlots; k++) coef[k] = '0;
      for (int t = 0; t < ThrusterSlots; t++) last_pub[t] = 0;
      scale  = ScaleReset;
      thresh = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CoefRegW-1:0] data);
      case (idx)
        REG_FORCE_SCALE:   scale  = data[ScaleW-1:0];
        REG_CHANGE_THRESH: thresh = data[ThrW-1:0];
        default:           coef[int'(idx)] = data;
      endcase
    endfunction

    // a * c / 2^15, rounded half away from zero
    function int round_term(int a, int c);
      int p;
      p = a * c;
      if (p >= 0) return (p + 16384) / 32768;
      return -((-p + 16384) / 32768);
    endfunction

    // accepted request: mix, compare against last published, maybe publish
    function void note_sample(axis_vec_t ax);
      int       mixed [ThrusterSlots];
      int       diff;
      bit       publish;
      longint   scaled;
      cmd_vec_t cmd;
      publish = 1'b0;
      for (int t = 0; t < ThrusterSlots; t++) begin
        mixed[t] = 0;
        for (int k = 0; k < AxisSlots; k++) begin
          mixed[t] += round_term(int'($signed(ax[k])),
                                 int'($signed(coef[k][CoefW*t +: CoefW])));
        end
        diff = mixed[t] - last_pub[t];
        if (diff < 0) diff = -diff;
        if (diff > int'(thresh)) publish = 1'b1;
      end
      if (publish) begin
        for (int t = 0; t < ThrusterSlots; t++) begin
          scaled      = longint'(mixed[t]) * longint'(scale);
          cmd[t]      = scaled[OutW-1:0];
          last_pub[t] = mixed[t];
        end
        expected_cmds.push_back(cmd);
      end
    endfunction

    function void check_command(cmd_vec_t got);
      cmd_vec_t want;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected command, nothing pending (thruster 0 = %0d)",
                 $time, $signed(got[0]));
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      for (int t = 0; t < ThrusterSlots; t++) begin
        if (got[t] !== want[t]) begin
          $display("%0t: thruster %0d mismatch: expected %0d, actual %0d",
                   $time, t, $signed(want[t]), $signed(got[t]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CoefRegW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  axis_vec_t           axes = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cmd_vec_t            thr_bus;

  thruster_mixer_send_on_delta_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .axis_0_i     (axes[0]),
    .axis_1_i     (axes[1]),
    .axis_2_i     (axes[2]),
    .axis_3_i     (axes[3]),
    .axis_4_i     (axes[4]),
    .axis_5_i     (axes[5]),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .thruster_0_o (thr_bus[0]),
    .thruster_1_o (thr_bus[1]),
    .thruster_2_o (thr_bus[2]),
    .thruster_3_o (thr_bus[3]),
    .thruster_4_o (thr_bus[4]),
    .thruster_5_o (thr_bus[5]),
    .thruster_6_o (thr_bus[6]),
    .thruster_7_o (thr_bus[7])
  );

  mix_scoreboard sb = new();
  int tx_idle_pct = 16;
  int rx_idle_pct = 78;
  int cycle_cnt = 0;

  // receiver: random stalls, checked on each accepted command
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_command(thr_bus);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_e idx, logic [CoefRegW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(axis_vec_t ax);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    axes     = ax;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(ax);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // sender holds off until every command is out and the core has settled
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCyc) @(negedge clk);
  endtask

  function automatic axis_vec_t fill_axes(logic [AxisW-1:0] v);
    axis_vec_t ax;
    for (int k = 0; k < AxisSlots; k++) ax[k] = v;
    return ax;
  endfunction

  function automatic logic [AxisW-1:0] extreme_axis();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  // mostly small moves around the last sample so the threshold decides
  function automatic axis_vec_t next_sample(axis_vec_t prev);
    axis_vec_t ax;
    int        mode;
    int        d;
    mode = $urandom_range(99);
    for (int k = 0; k < AxisSlots; k++) begin
      d = $urandom_range(1200) - 600;
      if (mode < 50)      ax[k] = prev[k] + d[AxisW-1:0];
      else if (mode < 70) ax[k] = AxisW'($urandom);
      else if (mode < 85) ax[k] = extreme_axis();
      else                ax[k] = prev[k];
    end
    return ax;
  endfunction

  function automatic logic [CoefRegW-1:0] random_coef_reg();
    logic [CoefRegW-1:0] r;
    case ($urandom_range(3))
      0: r = '0;                     // unmapped axis
      1: begin
        for (int t = 0; t < ThrusterSlots; t++) begin
          case ($urandom_range(3))
            0:       r[CoefW*t +: CoefW] = 8'h80;
            1:       r[CoefW*t +: CoefW] = 8'h7F;
            2:       r[CoefW*t +: CoefW] = 8'h01;
            default: r[CoefW*t +: CoefW] = 8'hFF;
          endcase
        end
      end
      default: r = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  // full register set; upper data bits of the narrow registers are junk
  task automatic program_random(logic [ScaleW-1:0] scale_val);
    logic [ThrW-1:0] th;
    for (int k = 0; k < AxisSlots; k++) write_reg(cfg_reg_e'(k), random_coef_reg());
    write_reg(REG_FORCE_SCALE, {$urandom, 16'($urandom_range(65535)), scale_val});
    th = ($urandom_range(3) == 0) ? ThrW'($urandom_range(400, 100))
                                  : ThrW'($urandom_range(15));
    write_reg(REG_CHANGE_THRESH, {$urandom, 16'($urandom_range(65535)), 5'd0, th});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    axis_vec_t ax;
    axis_vec_t prev;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // distinct coefficient per thruster, same on every axis
    for (int k = 0; k < AxisSlots; k++) write_reg(cfg_reg_e'(k), 64'h03C0_4000_FF7F_8001);
    write_reg(REG_FORCE_SCALE, 64'd1);
    write_reg(REG_CHANGE_THRESH, 64'd0);
    send_sample(fill_axes(16'h0000));   // equals reset state: no publish
    send_sample(fill_axes(16'h7FFF));
    send_sample(fill_axes(16'h8000));   // largest mixed magnitude
    send_sample(fill_axes(16'h4000));   // exact half rounds up
    send_sample(fill_axes(16'hC000));   // exact half rounds away, negative
    send_sample(fill_axes(16'h3FFF));   // just under half
    send_sample(fill_axes(16'h3FFF));   // unchanged: no publish
    for (int k = 0; k < AxisSlots; k++) ax[k] = k[0] ? 16'h8000 : 16'h7FFF;
    send_sample(ax);
    send_sample(fill_axes(16'hFFFF));
    wait_drained();

    // one mapped axis, threshold boundary, full scale
    write_reg(REG_COEF_AXIS_0, 64'h7F);
    for (int k = 1; k < AxisSlots; k++) write_reg(cfg_reg_e'(k), 64'd0);
    write_reg(REG_FORCE_SCALE, 64'hFFFF);
    write_reg(REG_CHANGE_THRESH, 64'd2);
    foreach (ax[k]) ax[k] = AxisW'($urandom);   // unmapped axes carry noise
    ax[0] = 16'd0;    send_sample(ax);
    ax[0] = 16'd516;  send_sample(ax);  // change of exactly the threshold
    ax[0] = 16'd774;  send_sample(ax);  // one above
    ax[0] = 16'd258;  send_sample(ax);
    ax[0] = 16'h8000; send_sample(ax);
    ax[0] = 16'h7FFF; send_sample(ax);
    wait_drained();

    // highest threshold never publishes; zero scale publishes zeros
    write_reg(REG_CHANGE_THRESH, 64'h7FF);
    write_reg(REG_FORCE_SCALE, 64'd0);
    send_sample(fill_axes(16'h8000));
    send_sample(fill_axes(16'h7FFF));
    send_sample(fill_axes(16'h0000));
    wait_drained();
    write_reg(REG_CHANGE_THRESH, 64'd0);
    send_sample(fill_axes(16'h8000));
    wait_drained();

    // random phases: sender-light, receiver-light, then no idling
    prev = fill_axes(16'h0000);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 16; rx_idle_pct = 78; end
        1: begin tx_idle_pct = 78; rx_idle_pct = 16; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (ph)
        0:       program_random(16'hFFFF);
        1:       program_random(ScaleW'($urandom_range(65535)));
        default: program_random(ScaleW'($urandom_range(300)));
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        ax = next_sample(prev);
        send_sample(ax);
        prev = ax;
      end
      wait_drained();
    end

    repeat (SettleCyc) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tmsod_pkg.sv
rtl/tmsod_lane.sv
rtl/thruster_mixer_send_on_delta_core.sv
tb/tb_thruster_mixer_send_on_delta_core.sv
